[src/svtd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package svtd_pkg;

	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

	// release tail in Q1.15, decay factor in Q0.16
	localparam logic [15:0] TAIL_ONE  = 16'd32768;
	localparam logic [15:0] TAIL_END  = 16'd163;
	localparam logic [15:0] DECAY_Q16 = 16'd64881;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// |sin| * level stays below 2^28 for every velocity
	localparam int MAG_W  = 28;
	localparam int PROD_W = MAG_W + 16;

	typedef struct packed {
		logic latch;
		logic exec;
		logic rom_rd;
		logic mul_lvl;
		logic mul_tail;
		logic decay;
		logic load_out;
		logic tick_fin;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       voice_on;
		logic       releasing;
	} status_t;

	// frequencies of notes 0..11 in Hz, unsigned Q.20
	function automatic logic [31:0] base_freq_q20(input int unsigned semi);
		logic [31:0] f;
		unique case (semi)
			0:       f = 32'd8572947;
			1:       f = 32'd9082720;
			2:       f = 32'd9622807;
			3:       f = 32'd10195009;
			4:       f = 32'd10801236;
			5:       f = 32'd11443511;
			6:       f = 32'd12123977;
			7:       f = 32'd12844906;
			8:       f = 32'd13608704;
			9:       f = 32'd14417920;
			10:      f = 32'd15275254;
			default: f = 32'd16183568;
		endcase
		return f;
	endfunction

	// quarter-wave entry from a seven-term Taylor series, Q1.15 capped at 32767
	function automatic logic [15:0] sine_q15(input int unsigned i, input int unsigned bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] v;
		x    = (64'(i) * HALF_PI_Q30) >> bits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			v = 64'd0;
		end else begin
			v = ($unsigned(sum) + 64'd16384) >> 15;
		end
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

[src/svtd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface svtd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [6:0] note;
	logic [6:0] velocity;
	logic       allow_tail_off;

	modport source (output valid, command, note, velocity, allow_tail_off, input ready);
	modport sink (input valid, command, note, velocity, allow_tail_off, output ready);
endinterface

`default_nettype wire

[src/svtd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface svtd_out_if #(
	parameter int OUT_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] sample;
	logic                       active;
	logic                       note_ended;

	modport source (output valid, sample, active, note_ended, input ready);
	modport sink (input valid, sample, active, note_ended, output ready);
endinterface

`default_nettype wire

[src/svtd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module svtd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  svtd_pkg::status_t st,
	output svtd_pkg::ctl_t    ctl
);
	import svtd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_LEVEL = 6'b000100,
		ST_TAIL  = 6'b001000,
		ST_DECAY = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   tick_path;

	assign tick_path = (st.cmd == CMD_TICK) && st.voice_on;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec   = 1'b1;
				ctl.rom_rd = 1'b1;
				state_d    = tick_path ? ST_LEVEL : ST_DONE;
			end
			ST_LEVEL: begin
				ctl.mul_lvl = 1'b1;
				state_d     = st.releasing ? ST_TAIL : ST_DONE;
			end
			ST_TAIL: begin
				ctl.mul_tail = 1'b1;
				state_d      = ST_DECAY;
			end
			ST_DECAY: begin
				ctl.decay = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					ctl.tick_fin = tick_path;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[src/svtd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module svtd_dp #(
	parameter int SAMPLE_RATE     = 48000,
	parameter int SINE_TABLE_BITS = 10,
	parameter int OUT_BITS        = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 in_command,
	input  logic [6:0]                 in_note,
	input  logic [6:0]                 in_velocity,
	input  logic                       in_allow,
	input  svtd_pkg::ctl_t             ctl,
	output svtd_pkg::status_t          st,
	output logic signed [OUT_BITS-1:0] sample,
	output logic                       active,
	output logic                       note_ended
);
	import svtd_pkg::*;

	localparam int QLEN   = (1 << SINE_TABLE_BITS) + 1;
	localparam int AW     = SINE_TABLE_BITS + 1;
	localparam int RND_SH = 31 - OUT_BITS;
	localparam logic [MAG_W:0] RND_ONE = (MAG_W + 1)'(1) << (30 - OUT_BITS);
	localparam logic [AW-1:0]  QTOP    = AW'(QLEN - 1);

	logic [15:0] sine_rom [QLEN];
	logic [15:0] amp_rom  [128];
	logic [31:0] step_rom [128];

	for (genvar i = 0; i < QLEN; i++) begin : g_sine
		assign sine_rom[i] = sine_q15(i, SINE_TABLE_BITS);
	end

	for (genvar i = 0; i < 128; i++) begin : g_note
		localparam int          OCT  = i / 12;
		localparam int          SEMI = i % 12;
		localparam logic [63:0] NUM  = 64'(base_freq_q20(SEMI)) << (OCT + 12);
		localparam logic [63:0] STEP = (NUM + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
		localparam int          AMP  = (i * 49152 + 635) / 1270;
		assign step_rom[i] = STEP[31:0];
		assign amp_rom[i]  = 16'(AMP);
	end

	// voice state
	logic [31:0] phase_q;
	logic [31:0] step_q;
	logic        voice_on_q;
	logic [15:0] amp_q;
	logic [15:0] tail_q;
	logic        releasing_q;
	logic        ended_q;

	// request and working registers
	logic [1:0]       cmd_q;
	logic [6:0]       note_q;
	logic [6:0]       vel_q;
	logic             allow_q;
	logic [15:0]      rom_q;
	logic [MAG_W-1:0] mag_q;

	logic [OUT_BITS-1:0] smp_out_q;
	logic                active_out_q;
	logic                ended_out_q;

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [AW-1:0]              addr;
	logic [MAG_W-1:0]           mul_a;
	logic [15:0]                mul_b;
	logic [PROD_W-1:0]          prod;
	logic [MAG_W:0]             rnd_sum;
	logic [OUT_BITS-1:0]        rmag;
	logic [OUT_BITS-1:0]        smp;
	logic                       tick_end;

	assign idx  = phase_q[29 -: SINE_TABLE_BITS];
	// mirror the index in the second and fourth quadrants
	assign addr = phase_q[30] ? (QTOP - AW'(idx)) : AW'(idx);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (ctl.mul_lvl) begin
			mul_a = MAG_W'(rom_q);
			mul_b = amp_q;
		end else if (ctl.mul_tail) begin
			mul_a = mag_q;
			mul_b = tail_q;
		end else if (ctl.decay) begin
			mul_a = MAG_W'(tail_q);
			mul_b = DECAY_Q16;
		end
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign rnd_sum  = {1'b0, mag_q} + RND_ONE;
	assign rmag     = OUT_BITS'(rnd_sum >> RND_SH);
	assign smp      = phase_q[31] ? (~rmag + OUT_BITS'(1)) : rmag;
	assign tick_end = ctl.tick_fin && releasing_q && (tail_q <= TAIL_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			step_q      <= '0;
			voice_on_q  <= 1'b0;
			amp_q       <= '0;
			tail_q      <= '0;
			releasing_q <= 1'b0;
			ended_q     <= 1'b0;
		end else begin
			if (ctl.latch) begin
				ended_q <= 1'b0;
			end
			if (ctl.exec) begin
				if (cmd_q == CMD_NOTE_ON) begin
					phase_q     <= '0;
					amp_q       <= amp_rom[vel_q];
					tail_q      <= '0;
					releasing_q <= 1'b0;
					step_q      <= step_rom[note_q];
					voice_on_q  <= 1'b1;
				end else if (cmd_q == CMD_NOTE_OFF && voice_on_q) begin
					if (allow_q) begin
						if (!releasing_q) begin
							releasing_q <= 1'b1;
							tail_q      <= TAIL_ONE;
						end
					end else begin
						voice_on_q  <= 1'b0;
						releasing_q <= 1'b0;
						tail_q      <= '0;
						step_q      <= '0;
						ended_q     <= 1'b1;
					end
				end
			end
			if (ctl.decay) begin
				tail_q <= prod[31:16];
			end
			if (ctl.tick_fin) begin
				phase_q <= phase_q + step_q;
				// drop the voice once the tail has faded out
				if (tick_end) begin
					voice_on_q  <= 1'b0;
					releasing_q <= 1'b0;
					tail_q      <= '0;
					step_q      <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= in_command;
			note_q  <= in_note;
			vel_q   <= in_velocity;
			allow_q <= in_allow;
		end
		if (ctl.rom_rd) begin
			rom_q <= sine_rom[addr];
		end
		if (ctl.mul_lvl) begin
			mag_q <= prod[MAG_W-1:0];
		end else if (ctl.mul_tail) begin
			mag_q <= prod[MAG_W+14:15];
		end
		if (ctl.load_out) begin
			smp_out_q    <= ctl.tick_fin ? smp : '0;
			active_out_q <= voice_on_q && !tick_end;
			ended_out_q  <= ended_q || tick_end;
		end
	end

	assign st.cmd       = cmd_q;
	assign st.voice_on  = voice_on_q;
	assign st.releasing = releasing_q;

	assign sample     = $signed(smp_out_q);
	assign active     = active_out_q;
	assign note_ended = ended_out_q;

endmodule

`default_nettype wire

[src/sine_voice_with_tail_decay.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Carries
// cmd      in   command, note, velocity, allow_tail_off (one request per command)
// result   out  sample, active, note_ended (one per request)
//
// A request holds the block through exec and done for note on, note off, unused
// commands and idle ticks, adds level for a sounding tick outside release and level,
// tail and decay for a tick in release: the one shared multiplier takes level, tail
// and decay in turn. The result turns valid in the cycle the block is ready again.
// The next request is taken while a result still waits on result.ready; a
// stalled result holds the block in its last step only.
// Reset clears the voice to silence; the sine, pitch and level tables are constant.

module sine_voice_with_tail_decay #(
	parameter int SAMPLE_RATE     = 48000,
	parameter int SINE_TABLE_BITS = 10,
	parameter int OUT_BITS        = 16
) (
	input logic        clk,
	input logic        arst_n,
	svtd_in_if.sink    cmd,
	svtd_out_if.source result
);
	import svtd_pkg::*;

	ctl_t    ctl;
	status_t st;

	svtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.ctl       (ctl)
	);

	svtd_dp #(
		.SAMPLE_RATE     (SAMPLE_RATE),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.OUT_BITS        (OUT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_command  (cmd.command),
		.in_note     (cmd.note),
		.in_velocity (cmd.velocity),
		.in_allow    (cmd.allow_tail_off),
		.ctl         (ctl),
		.st          (st),
		.sample      (result.sample),
		.active      (result.active),
		.note_ended  (result.note_ended)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!result.valid || result.ready))
		else $error("result overwritten while pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("request accepted while busy");

	a_tail_only_releasing: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.mul_tail || ctl.decay) |-> st.releasing)
		else $error("tail step outside release");

	a_silent_non_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load_out && !ctl.tick_fin) |=> (result.sample == '0))
		else $error("nonzero sample without a sounding tick");

endmodule

`default_nettype wire
